### sv/ajsc_pkg.sv
`timescale 1ns / 1ps
// Package of the arm joint step chooser: constants, types and the arctangent table.
package ajsc_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_ITERS = 18;
  localparam int CW           = 34;
  localparam int TRIG_W       = 18;
  localparam int TIP_W        = 20;
  localparam int DIFF_W       = 21;
  localparam int SQ_W         = 42;
  localparam int UNIT_W       = 32;
  localparam int COST_W       = 44;
  localparam int UNIT_SHIFT   = 2 * ANGLE_BITS - 14;

  localparam logic [29:0] GAIN_Q30       = 30'd652032874;
  localparam logic [29:0] FOUR_PI_SQ_Q24 = 30'd662337940;
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  localparam logic [2:0] REG_STEP   = 3'd0;
  localparam logic [2:0] REG_LINK1  = 3'd1;
  localparam logic [2:0] REG_LINK2  = 3'd2;
  localparam logic [2:0] REG_LINK3  = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;
  localparam logic [2:0] REG_WEIGHT = 3'd5;

  localparam logic [1:0] DIG_MINUS = 2'd0;
  localparam logic [1:0] DIG_HOLD  = 2'd1;
  localparam logic [1:0] DIG_PLUS  = 2'd2;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [15:0]        joint_one_angle;
    logic [15:0]        joint_two_angle;
    logic [15:0]        joint_three_angle;
  } in_data_t;

  typedef struct packed {
    logic               raise_one;
    logic               raise_two;
    logic               raise_three;
    logic               lower_one;
    logic               lower_two;
    logic               lower_three;
    logic signed [15:0] tip_x;
    logic signed [15:0] tip_z;
  } out_data_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [15:0] value;
  } cfg_data_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         d1;
    logic [1:0]         d2;
    logic [1:0]         d3;
    logic               pose;
    logic signed [15:0] tgx;
    logic signed [15:0] tgy;
  } tag_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [1:0]           q;
    tag_t                 tag;
  } cordic_t;

  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051D;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2E;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2F9;
      5'd15: v = 30'h0000517C;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

### sv/ajsc_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the arm joint step chooser: input, result and configuration.
interface ajsc_in_if;
  import ajsc_pkg::*;
  logic     valid;
  logic     ready;
  in_data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ajsc_out_if;
  import ajsc_pkg::*;
  logic      valid;
  logic      ready;
  out_data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ajsc_cfg_if;
  import ajsc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_data_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/ajsc_cell.sv
`timescale 1ns / 1ps
// One CORDIC rotation cell: a single micro-rotation, registered.
module ajsc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [4:0]        stage_idx,
  input  ajsc_pkg::cordic_t cin,
  output ajsc_pkg::cordic_t c_r
);
  import ajsc_pkg::*;

  cordic_t              c_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;

  always_comb begin
    dx    = cin.y >>> stage_idx;
    dy    = cin.x >>> stage_idx;
    at    = $signed({{(CW-30){1'b0}}, atan_turn(stage_idx)});
    c_nxt = cin;
    if (!cin.z[CW-1]) begin
      c_nxt.x = cin.x - dx;
      c_nxt.y = cin.y + dy;
      c_nxt.z = cin.z - at;
    end else begin
      c_nxt.x = cin.x + dx;
      c_nxt.y = cin.y - dy;
      c_nxt.z = cin.z + at;
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
    if (!rst_n) begin
      c_r.tag.valid <= 1'b0;
    end
  end

endmodule

### sv/ajsc_lane.sv
`timescale 1ns / 1ps
// One link lane: quadrant reduction, a chain of CORDIC cells and the quadrant fold.
module ajsc_lane (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ajsc_pkg::ANGLE_BITS-1:0]     angle,
  input  logic [13:0]                         len,
  input  ajsc_pkg::tag_t                      tag_in,
  output logic signed [ajsc_pkg::TRIG_W-1:0]  cos_r,
  output logic signed [ajsc_pkg::TRIG_W-1:0]  sin_r,
  output ajsc_pkg::tag_t                      tag_r
);
  import ajsc_pkg::*;

  cordic_t     chain [0:CORDIC_ITERS];
  cordic_t     head_nxt;
  logic [31:0] a32;
  logic [31:0] qsum;
  logic [31:0] resid;
  logic [43:0] prod;

  logic signed [CW-1:0]     xr;
  logic signed [CW-1:0]     yr;
  logic signed [TRIG_W-1:0] cc;
  logic signed [TRIG_W-1:0] ss;
  logic signed [TRIG_W-1:0] cos_nxt;
  logic signed [TRIG_W-1:0] sin_nxt;

  always_comb begin
    a32          = {angle, {(32-ANGLE_BITS){1'b0}}};
    qsum         = a32 + 32'h2000_0000;
    resid        = a32 - {qsum[31:30], 30'd0};
    prod         = 44'(len) * 44'(GAIN_Q30);
    head_nxt.q   = qsum[31:30];
    head_nxt.z   = CW'($signed(resid));
    head_nxt.x   = $signed({{(CW-30){1'b0}}, prod[43:14]});
    head_nxt.y   = '0;
    head_nxt.tag = tag_in;
  end

  always_ff @(posedge clk) begin
    chain[0] <= head_nxt;
    if (!rst_n) begin
      chain[0].tag.valid <= 1'b0;
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_cell
    ajsc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (5'(i)),
      .cin       (chain[i]),
      .c_r       (chain[i+1])
    );
  end

  always_comb begin
    xr = (chain[CORDIC_ITERS].x + CW'(32768)) >>> 16;
    yr = (chain[CORDIC_ITERS].y + CW'(32768)) >>> 16;
    cc = xr[TRIG_W-1:0];
    ss = yr[TRIG_W-1:0];
    case (chain[CORDIC_ITERS].q)
      2'd0: begin cos_nxt = cc;  sin_nxt = ss;  end
      2'd1: begin cos_nxt = -ss; sin_nxt = cc;  end
      2'd2: begin cos_nxt = -cc; sin_nxt = -ss; end
      default: begin cos_nxt = ss; sin_nxt = -cc; end
    endcase
  end

  always_ff @(posedge clk) begin
    cos_r <= cos_nxt;
    sin_r <= sin_nxt;
    tag_r <= chain[CORDIC_ITERS].tag;
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end
  end

endmodule

### sv/ajsc_cost.sv
`timescale 1ns / 1ps
// Cost unit: tip sum, squared distance plus step penalty, and the running minimum.
module ajsc_cost (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [ajsc_pkg::TRIG_W-1:0] c1,
  input  logic signed [ajsc_pkg::TRIG_W-1:0] c2,
  input  logic signed [ajsc_pkg::TRIG_W-1:0] c3,
  input  logic signed [ajsc_pkg::TRIG_W-1:0] s1,
  input  logic signed [ajsc_pkg::TRIG_W-1:0] s2,
  input  logic signed [ajsc_pkg::TRIG_W-1:0] s3,
  input  ajsc_pkg::tag_t                     tag,
  input  logic signed [13:0]                 offset_x,
  input  logic [ajsc_pkg::UNIT_W+1:0]        unit1,
  input  logic [ajsc_pkg::UNIT_W+1:0]        unit2,
  input  logic [ajsc_pkg::UNIT_W+1:0]        unit3,
  input  logic                               step_nz,
  output logic                               res_valid_r,
  output ajsc_pkg::out_data_t                res_r
);
  import ajsc_pkg::*;

  tag_t                     tag_a_r, tag_b_r, tag_c_r;
  logic signed [TIP_W-1:0]  tx_a_r, tz_a_r, tx_b_r, tz_b_r, tx_c_r, tz_c_r;
  logic signed [DIFF_W-1:0] dx_a_r, dy_a_r;
  logic [SQ_W-1:0]          sqx_b_r, sqy_b_r;
  logic [UNIT_W+1:0]        pen_b_r;
  logic [COST_W-1:0]        cost_c_r;
  logic [COST_W-1:0]        best_r;
  logic [1:0]               b1_r, b2_r, b3_r;

  logic signed [TIP_W-1:0]    tx, tz;
  logic signed [2*DIFF_W-1:0] px, py;
  logic [1:0]                 nstep;
  logic [UNIT_W+1:0]          pen;
  logic                       first;
  logic                       take;
  out_data_t                  res_nxt;

  function automatic logic signed [15:0] sat16(input logic signed [TIP_W-1:0] v);
    logic signed [15:0] r;
    if (v > TIP_W'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -TIP_W'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Stage A: tip of the candidate and its offset from the target.
  always_comb begin
    tx = TIP_W'(c1) + TIP_W'(c2) + TIP_W'(c3) + TIP_W'(offset_x);
    tz = TIP_W'(s1) + TIP_W'(s2) + TIP_W'(s3);
  end

  always_ff @(posedge clk) begin
    tag_a_r <= tag;
    tx_a_r  <= tx;
    tz_a_r  <= tz;
    dx_a_r  <= DIFF_W'(tx) - DIFF_W'(tag.tgx);
    dy_a_r  <= DIFF_W'(tz) - DIFF_W'(tag.tgy);
    if (!rst_n) begin
      tag_a_r.valid <= 1'b0;
    end
  end

  // Stage B: squares and the step penalty for the number of joints that move.
  always_comb begin
    px    = dx_a_r * dx_a_r;
    py    = dy_a_r * dy_a_r;
    nstep = 2'((tag_a_r.d1 != DIG_HOLD)) + 2'((tag_a_r.d2 != DIG_HOLD))
          + 2'((tag_a_r.d3 != DIG_HOLD));
    case (nstep)
      2'd1:    pen = unit1;
      2'd2:    pen = unit2;
      2'd3:    pen = unit3;
      default: pen = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    tag_b_r <= tag_a_r;
    tx_b_r  <= tx_a_r;
    tz_b_r  <= tz_a_r;
    sqx_b_r <= px[SQ_W-1:0];
    sqy_b_r <= py[SQ_W-1:0];
    pen_b_r <= pen;
    if (!rst_n) begin
      tag_b_r.valid <= 1'b0;
    end
  end

  // Stage C: full-width cost.
  always_ff @(posedge clk) begin
    tag_c_r  <= tag_b_r;
    tx_c_r   <= tx_b_r;
    tz_c_r   <= tz_b_r;
    cost_c_r <= COST_W'(sqx_b_r) + COST_W'(sqy_b_r) + COST_W'(pen_b_r);
    if (!rst_n) begin
      tag_c_r.valid <= 1'b0;
    end
  end

  // Stage D: keep the first strictly cheapest candidate; the pose job closes the item.
  always_comb begin
    first = (tag_c_r.d1 == DIG_MINUS) && (tag_c_r.d2 == DIG_MINUS)
         && (tag_c_r.d3 == DIG_MINUS);
    take  = tag_c_r.valid && !tag_c_r.pose && (first || (cost_c_r < best_r));
    res_nxt.raise_one   = step_nz && (b1_r == DIG_PLUS);
    res_nxt.raise_two   = step_nz && (b2_r == DIG_PLUS);
    res_nxt.raise_three = step_nz && (b3_r == DIG_PLUS);
    res_nxt.lower_one   = step_nz && (b1_r == DIG_MINUS);
    res_nxt.lower_two   = step_nz && (b2_r == DIG_MINUS);
    res_nxt.lower_three = step_nz && (b3_r == DIG_MINUS);
    res_nxt.tip_x       = sat16(tx_c_r);
    res_nxt.tip_z       = sat16(tz_c_r);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r <= cost_c_r;
      b1_r   <= tag_c_r.d1;
      b2_r   <= tag_c_r.d2;
      b3_r   <= tag_c_r.d3;
    end
    res_r <= res_nxt;
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= tag_c_r.valid && tag_c_r.pose;
    end
  end

endmodule

### sv/arm_joint_step_chooser.sv
`timescale 1ns / 1ps
// Top level of the arm joint step chooser.
// Each accepted item issues 28 jobs, one per cycle: the 27 step combinations
// in loop order and then the current pose. Every job runs through three
// parallel CORDIC lanes (one per link, 18 rotation cells each) and a
// four-stage cost unit, which gives one result per item. A new item is
// taken only while the job sequencer is idle and fewer than two items are
// outstanding; up to two may be outstanding while results wait in a
// two-entry output queue. Configuration writes are taken in every cycle; the
// step penalty derived from them passes through sq_r, m1_r, unit1_r, then unit2_r and unit3_r.
module arm_joint_step_chooser (
  input logic clk,
  input logic rst_n,
  ajsc_in_if.sink    in_ch,
  ajsc_out_if.source out_ch,
  ajsc_cfg_if.sink   cfg_ch
);
  import ajsc_pkg::*;

  // Configuration registers.
  logic [13:0]        step_r, link1_r, link2_r, link3_r;
  logic signed [13:0] offset_r;
  logic [15:0]        weight_r;

  // Step penalty pipeline.
  logic [27:0]       sq_r;
  logic [57:0]       m1_r;
  logic [49:0]       m2;
  logic [UNIT_W+1:0] unit1_r, unit2_r, unit3_r;

  // Job sequencer.
  logic                  busy_r;
  logic [1:0]            d1_r, d2_r, d3_r;
  logic                  pose_r;
  logic [ANGLE_BITS-1:0] th1_r, th2_r, th3_r;
  logic signed [15:0]    tgx_r, tgy_r;
  logic [1:0]            cnt_r;
  logic [1:0]            cnt_nxt;

  logic                  in_xfer, out_xfer, cfg_xfer;
  logic [ANGLE_BITS-1:0] step_a;
  logic [ANGLE_BITS-1:0] a1, a2, a3;
  tag_t                  job;

  logic signed [TRIG_W-1:0] cs [0:2];
  logic signed [TRIG_W-1:0] sn [0:2];
  tag_t                     ltag [0:2];

  logic      res_valid;
  out_data_t res;

  // Output queue.
  out_data_t q_mem [0:1];
  logic      q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;

  function automatic logic [ANGLE_BITS-1:0] off_of(input logic [1:0] d,
                                                   input logic [ANGLE_BITS-1:0] s);
    logic [ANGLE_BITS-1:0] r;
    case (d)
      DIG_MINUS: r = -s;
      DIG_PLUS:  r = s;
      default:   r = '0;
    endcase
    return r;
  endfunction

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !busy_r && (cnt_r != 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= 14'd182;
      link1_r  <= 14'd2376;
      link2_r  <= 14'd3865;
      link3_r  <= 14'd6867;
      offset_r <= -14'sd451;
      weight_r <= 16'd6554;
    end else if (cfg_xfer) begin
      case (cfg_ch.data.index)
        REG_STEP:   step_r   <= cfg_ch.data.value[13:0];
        REG_LINK1:  link1_r  <= cfg_ch.data.value[13:0];
        REG_LINK2:  link2_r  <= cfg_ch.data.value[13:0];
        REG_LINK3:  link3_r  <= cfg_ch.data.value[13:0];
        REG_OFFSET: offset_r <= $signed(cfg_ch.data.value[13:0]);
        REG_WEIGHT: weight_r <= cfg_ch.data.value;
        default: ;
      endcase
    end
  end

  assign m2 = 50'(m1_r[57:24]) * 50'(weight_r);

  always_ff @(posedge clk) begin
    sq_r    <= 28'(step_r) * 28'(step_r);
    m1_r    <= 58'(sq_r) * 58'(FOUR_PI_SQ_Q24);
    unit1_r <= (UNIT_W+2)'(m2[UNIT_SHIFT +: UNIT_W]);
    unit2_r <= unit1_r << 1;
    unit3_r <= (unit1_r << 1) + unit1_r;
  end

  // Sequencer: counts the three joint digits, then issues the pose job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pose_r <= 1'b0;
      d1_r   <= DIG_MINUS;
      d2_r   <= DIG_MINUS;
      d3_r   <= DIG_MINUS;
    end else if (in_xfer) begin
      busy_r <= 1'b1;
      pose_r <= 1'b0;
      d1_r   <= DIG_MINUS;
      d2_r   <= DIG_MINUS;
      d3_r   <= DIG_MINUS;
    end else if (busy_r) begin
      if (pose_r) begin
        busy_r <= 1'b0;
      end else if (d3_r != DIG_PLUS) begin
        d3_r <= d3_r + 2'd1;
      end else begin
        d3_r <= DIG_MINUS;
        if (d2_r != DIG_PLUS) begin
          d2_r <= d2_r + 2'd1;
        end else begin
          d2_r <= DIG_MINUS;
          if (d1_r != DIG_PLUS) begin
            d1_r <= d1_r + 2'd1;
          end else begin
            d1_r   <= DIG_MINUS;
            pose_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      th1_r <= in_ch.data.joint_one_angle[ANGLE_BITS-1:0];
      th2_r <= in_ch.data.joint_two_angle[ANGLE_BITS-1:0];
      th3_r <= in_ch.data.joint_three_angle[ANGLE_BITS-1:0];
      tgx_r <= in_ch.data.target_x;
      tgy_r <= in_ch.data.target_y;
    end
  end

  always_comb begin
    step_a = ANGLE_BITS'(step_r);
    if (pose_r) begin
      a1 = th1_r + QUARTER_TURN;
      a2 = a1 + th2_r;
      a3 = a2 + th3_r;
    end else begin
      a1 = th1_r + off_of(d1_r, step_a) + QUARTER_TURN;
      a2 = a1 + th2_r + off_of(d2_r, step_a);
      a3 = a2 + th3_r + off_of(d3_r, step_a);
    end
    job.valid = busy_r;
    job.d1    = d1_r;
    job.d2    = d2_r;
    job.d3    = d3_r;
    job.pose  = pose_r;
    job.tgx   = tgx_r;
    job.tgy   = tgy_r;
  end

  ajsc_lane u_lane1 (
    .clk (clk), .rst_n (rst_n), .angle (a1), .len (link1_r), .tag_in (job),
    .cos_r (cs[0]), .sin_r (sn[0]), .tag_r (ltag[0])
  );
  ajsc_lane u_lane2 (
    .clk (clk), .rst_n (rst_n), .angle (a2), .len (link2_r), .tag_in (job),
    .cos_r (cs[1]), .sin_r (sn[1]), .tag_r (ltag[1])
  );
  ajsc_lane u_lane3 (
    .clk (clk), .rst_n (rst_n), .angle (a3), .len (link3_r), .tag_in (job),
    .cos_r (cs[2]), .sin_r (sn[2]), .tag_r (ltag[2])
  );

  ajsc_cost u_cost (
    .clk (clk), .rst_n (rst_n),
    .c1 (cs[0]), .c2 (cs[1]), .c3 (cs[2]),
    .s1 (sn[0]), .s2 (sn[1]), .s3 (sn[2]),
    .tag (ltag[0]), .offset_x (offset_r),
    .unit1 (unit1_r), .unit2 (unit2_r), .unit3 (unit3_r),
    .step_nz (step_r != 14'd0),
    .res_valid_r (res_valid), .res_r (res)
  );

  // Items accepted but not yet delivered; at most two keeps the queue from overflowing.
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer && !out_xfer) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_mem[q_wp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (res_valid) begin
        q_wp_r <= !q_wp_r;
      end
      if (out_xfer) begin
        q_rp_r <= !q_rp_r;
      end
      q_cnt_r <= q_cnt_r + 2'(res_valid) - 2'(out_xfer);
    end
  end

  assign out_ch.valid = (q_cnt_r != 2'd0);
  assign out_ch.data  = q_mem[q_rp_r];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("outstanding item count exceeded two");
  a_queue_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= cnt_r) else $error("queue holds more results than outstanding items");
  a_queue_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> q_cnt_r != 2'd2) else $error("result arrived at a full queue");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy_r && !pose_r) else $error("sequencer did not start after a transfer");

endmodule
